/* rtl/core/pli_pkg.sv */
// Shared types and constants for the piecewise linear interpolator.
// Holds the payload structs, the status codes and the divider sizing.
// No dependencies.
package pli_pkg;

	// Widths of the Q16.16 fields, the exact product and the quotient.
	localparam int FIELD_W = 32;
	localparam int PROD_W  = 64;
	localparam int QUO_W   = 41;
	localparam int CFG_W   = 5;

	// Largest quotient magnitude that is still added to the base value.
	localparam logic [QUO_W-1:0] QUO_LIMIT = 41'h100_0000_0000;

	// Request kinds.
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_ZERO_WIDTH  = 2'd1;
	localparam logic [1:0] ST_SATURATED   = 2'd2;
	localparam logic [1:0] ST_FEW_POINTS  = 2'd3;

	// Saturation bounds of the signed result.
	localparam logic signed [FIELD_W-1:0] RES_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [FIELD_W-1:0] RES_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic                      req_type;
		logic [3:0]                entry_index;
		logic signed [FIELD_W-1:0] entry_position;
		logic signed [FIELD_W-1:0] entry_value;
		logic signed [FIELD_W-1:0] query_value;
	} in_item_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] result_value;
		logic [1:0]                status;
	} out_item_t;

	// One breakpoint pair as held by a ring cell.
	typedef struct packed {
		logic signed [FIELD_W-1:0] position;
		logic signed [FIELD_W-1:0] value;
	} entry_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctrl_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} div_status_t;

endpackage

/* rtl/core/pli_cell.sv */
// One cell of the breakpoint ring: holds a single (position, value) pair.
// Depends on pli_pkg for the entry and control types.
module pli_cell import pli_pkg::*; (
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  entry_t     load_data,
	input  entry_t     next_data,
	output entry_t     data
);

	entry_t data_q;

	// A table write has priority; otherwise the ring advances by one cell.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			data_q <= load_data;
		end else if (ctrl.shift) begin
			data_q <= next_data;
		end
	end

	assign data = data_q;

endmodule

/* rtl/core/pli_div.sv */
// Restoring divider for the interpolation step: 64-bit magnitude over
// 32-bit magnitude, one quotient bit per cycle. Depends on pli_pkg.
module pli_div import pli_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [PROD_W-1:0]  num,
	input  logic [FIELD_W-1:0] den,
	output logic [QUO_W-1:0]   quo,
	output div_status_t        st
);

	localparam int CW   = $clog2(QUO_W + 1);
	localparam int HI_W = PROD_W - QUO_W;

	logic                busy_q;
	logic                done_q;
	logic                ovf_q;
	logic [CW-1:0]       cnt_q;
	logic [FIELD_W-1:0]  rem_q;
	logic [FIELD_W-1:0]  den_q;
	logic [QUO_W-1:0]    nq_q;
	logic [FIELD_W-1:0]  num_hi;
	logic                num_ovf;
	logic [FIELD_W:0]    trial;
	logic                fits;

	// If the top bits already reach the divisor the quotient cannot fit.
	assign num_hi  = FIELD_W'(num[PROD_W-1:QUO_W]);
	assign num_ovf = (num_hi >= den);

	// One restoring step: bring in the next numerator bit and try to subtract.
	assign trial = {rem_q, nq_q[QUO_W-1]};
	assign fits  = (trial >= {1'b0, den_q});

	// Control: step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= !num_ovf;
				done_q <= num_ovf;
				ovf_q  <= num_ovf;
				cnt_q  <= CW'(QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: partial remainder and the numerator/quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= num_hi;
			nq_q  <= num[QUO_W-1:0];
		end else if (busy_q) begin
			rem_q <= fits ? FIELD_W'(trial - {1'b0, den_q}) : trial[FIELD_W-1:0];
			nq_q  <= {nq_q[QUO_W-2:0], fits};
		end
	end

	assign quo     = nq_q;
	assign st.done = done_q;
	assign st.ovf  = ovf_q;

	// HI_W documents how many numerator bits seed the remainder.
	if (HI_W > FIELD_W) begin : g_width_check
		assign quo[0] = 1'b0;
	end

endmodule

/* rtl/core/piecewise_linear_interpolator_unit.sv */
// Piecewise linear interpolator; uses pli_pkg, pli_cell and pli_div.
// A write transaction loads its cell and leaves the block idle. In a query, each binary
// search probe waits for its entry to rotate to the head of the cell ring, the segment
// ends are picked off the ring, and the 41-step divider then runs. One query is in
// flight at a time.
// Reset clears control state and point_count; the breakpoint table is not cleared.
module piecewise_linear_interpolator_unit import pli_pkg::*; #(
	parameter int MAX_POINTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IDXW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNTW = $clog2(MAX_POINTS + 1);

	// Register word index.
	localparam logic REG_POINT_COUNT = 1'b0;

	// Sequencer states.
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SEARCH = 4'd1;
	localparam logic [3:0] S_FETCH  = 4'd2;
	localparam logic [3:0] S_PREP   = 4'd3;
	localparam logic [3:0] S_MUL    = 4'd4;
	localparam logic [3:0] S_DIV_GO = 4'd5;
	localparam logic [3:0] S_DIV    = 4'd6;
	localparam logic [3:0] S_SAT    = 4'd7;
	localparam logic [3:0] S_DONE   = 4'd8;

	function automatic logic [FIELD_W-1:0] mag33(input logic [FIELD_W:0] d);
		logic [FIELD_W:0] neg_d;
		neg_d = -d;
		return d[FIELD_W] ? neg_d[FIELD_W-1:0] : d[FIELD_W-1:0];
	endfunction

	logic [3:0]                state_q;
	logic [CFG_W-1:0]          point_count_q;
	logic [IDXW-1:0]           head_q;
	logic                      got_first_q;
	logic                      out_valid_q;
	out_item_t                 out_data_q;

	logic [CNTW-1:0]           n_q;
	logic [CNTW-1:0]           lo_q;
	logic [CNTW-1:0]           hi_q;
	logic [IDXW-1:0]           seg_q;
	logic signed [FIELD_W-1:0] x_q;
	logic signed [FIELD_W-1:0] a1_q;
	logic signed [FIELD_W-1:0] a2_q;
	logic signed [FIELD_W-1:0] b1_q;
	logic signed [FIELD_W-1:0] b2_q;
	logic [FIELD_W-1:0]        mdx_q;
	logic [FIELD_W-1:0]        mdy_q;
	logic [FIELD_W-1:0]        mden_q;
	logic                      neg_q;
	logic [PROD_W-1:0]         prod_q;
	logic signed [FIELD_W-1:0] res_q;
	logic [1:0]                stat_q;

	logic                      in_fire;
	logic                      write_fire;
	logic                      query_fire;
	logic                      rotate;
	logic                      out_free;
	logic                      cfg_wr;
	logic [CNTW-1:0]           n_eff;
	logic [CNTW:0]             mid_sum;
	logic [CNTW-1:0]           mid;
	logic                      probe_hit;
	logic [CNTW-1:0]           seg_next;
	logic [IDXW-1:0]           seg_prev;
	logic [IDXW-1:0]           slot;
	logic [IDXW:0]             pdiff;
	logic [IDXW-1:0]           phys;
	logic [IDXW-1:0]           head_next;
	entry_t                    new_entry;
	entry_t                    head_entry;
	entry_t                    cell_data [MAX_POINTS];
	cell_ctrl_t                cell_ctrl [MAX_POINTS];

	logic [FIELD_W:0]          den_w;
	logic [FIELD_W:0]          dx_w;
	logic [FIELD_W:0]          dy_w;
	logic [QUO_W-1:0]          div_quo;
	div_status_t               div_st;
	logic [QUO_W+1:0]          q_mag;
	logic [QUO_W+1:0]          sq_w;
	logic [QUO_W+1:0]          sum_w;
	logic signed [FIELD_W-1:0] sat_res;
	logic [1:0]                sat_stat;

	// Handshakes.
	assign in_stall   = (state_q != S_IDLE);
	assign in_fire    = in_valid && !in_stall;
	assign write_fire = in_fire && (in_data.req_type == REQ_WRITE);
	assign query_fire = in_fire && (in_data.req_type == REQ_QUERY);
	assign out_free   = !out_valid_q || !out_stall;
	assign out_valid  = out_valid_q;
	assign out_data   = out_data_q;
	assign rotate     = (state_q == S_SEARCH) || (state_q == S_FETCH);

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[2])
			REG_POINT_COUNT: prdata = 32'(point_count_q);
			default:         prdata = '0;
		endcase
	end

	// Points in use, limited to the table size.
	assign n_eff = (32'(point_count_q) > MAX_POINTS) ? CNTW'(MAX_POINTS)
	                                                 : CNTW'(point_count_q);

	// Table slot of a write, reduced to the table size.
	if (MAX_POINTS >= 16) begin : g_slot_wide
		assign slot = IDXW'(in_data.entry_index);
	end else begin : g_slot_mod
		logic [4:0] slot_v;
		always_comb begin
			slot_v = {1'b0, in_data.entry_index};
			for (int k = 0; k < 8; k++) begin
				if (slot_v >= 5'(MAX_POINTS)) begin
					slot_v = slot_v - 5'(MAX_POINTS);
				end
			end
		end
		assign slot = slot_v[IDXW-1:0];
	end

	// The ring has turned by head_q, so slot s sits in cell (s - head_q) mod N.
	assign pdiff = {1'b0, slot} - {1'b0, head_q};
	assign phys  = (slot >= head_q) ? pdiff[IDXW-1:0]
	                                : IDXW'(pdiff + (IDXW+1)'(MAX_POINTS));
	assign head_next = (head_q == IDXW'(MAX_POINTS - 1)) ? '0 : head_q + 1'b1;

	assign new_entry.position = in_data.entry_position;
	assign new_entry.value    = in_data.entry_value;

	// Ring of breakpoint cells; cell 0 is the only read point.
	for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
		assign cell_ctrl[i].load  = write_fire && (phys == IDXW'(i));
		assign cell_ctrl[i].shift = rotate;
		pli_cell u_cell (
			.clk       (clk),
			.ctrl      (cell_ctrl[i]),
			.load_data (new_entry),
			.next_data (cell_data[(i + 1) % MAX_POINTS]),
			.data      (cell_data[i])
		);
	end
	assign head_entry = cell_data[0];

	// Binary search probe and the segment clamp.
	assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid       = mid_sum[CNTW:1];
	assign probe_hit = (CNTW'(head_q) == mid);

	always_comb begin
		if (lo_q == '0) begin
			seg_next = CNTW'(1);
		end else if (lo_q >= n_q) begin
			seg_next = n_q - 1'b1;
		end else begin
			seg_next = lo_q;
		end
	end
	assign seg_prev = seg_q - 1'b1;

	// Exact 33-bit differences of the segment.
	assign den_w = {a2_q[FIELD_W-1], a2_q} - {a1_q[FIELD_W-1], a1_q};
	assign dx_w  = {x_q[FIELD_W-1], x_q} - {a1_q[FIELD_W-1], a1_q};
	assign dy_w  = {b2_q[FIELD_W-1], b2_q} - {b1_q[FIELD_W-1], b1_q};

	pli_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_DIV_GO),
		.num    (prod_q),
		.den    (mden_q),
		.quo    (div_quo),
		.st     (div_st)
	);

	// Apply the sign, add the base value and saturate.
	assign q_mag = {2'b00, div_quo};
	assign sq_w  = neg_q ? -q_mag : q_mag;
	assign sum_w = {{(QUO_W+2-FIELD_W){b1_q[FIELD_W-1]}}, b1_q} + sq_w;

	always_comb begin
		sat_res  = sum_w[FIELD_W-1:0];
		sat_stat = ST_OK;
		if (div_st.ovf || (div_quo > QUO_LIMIT)) begin
			sat_res  = neg_q ? RES_MIN : RES_MAX;
			sat_stat = ST_SATURATED;
		end else if (!sum_w[QUO_W+1] && (sum_w[QUO_W:FIELD_W-1] != '0)) begin
			sat_res  = RES_MAX;
			sat_stat = ST_SATURATED;
		end else if (sum_w[QUO_W+1] && (sum_w[QUO_W:FIELD_W-1] != '1)) begin
			sat_res  = RES_MIN;
			sat_stat = ST_SATURATED;
		end
	end

	// Sequencer, ring position, output valid and the register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			point_count_q <= '0;
			head_q        <= '0;
			got_first_q   <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr && (paddr[2] == REG_POINT_COUNT)) begin
				point_count_q <= pwdata[CFG_W-1:0];
			end
			if (rotate) begin
				head_q <= head_next;
			end
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (query_fire) begin
						state_q <= (n_eff < CNTW'(2)) ? S_DONE : S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (lo_q >= hi_q) begin
						state_q     <= S_FETCH;
						got_first_q <= 1'b0;
					end
				end
				S_FETCH: begin
					if (got_first_q) begin
						state_q <= S_PREP;
					end else if (head_q == seg_prev) begin
						got_first_q <= 1'b1;
					end
				end
				S_PREP: begin
					state_q <= (den_w == '0) ? S_DONE : S_MUL;
				end
				S_MUL: begin
					state_q <= S_DIV_GO;
				end
				S_DIV_GO: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_st.done) begin
						state_q <= S_SAT;
					end
				end
				S_SAT: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Query datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (query_fire) begin
					x_q    <= in_data.query_value;
					n_q    <= n_eff;
					lo_q   <= '0;
					hi_q   <= n_eff;
					res_q  <= '0;
					stat_q <= ST_FEW_POINTS;
				end
			end
			S_SEARCH: begin
				if (lo_q >= hi_q) begin
					seg_q <= IDXW'(seg_next);
				end else if (probe_hit) begin
					if ($signed(head_entry.position) < $signed(x_q)) begin
						lo_q <= mid + 1'b1;
					end else begin
						hi_q <= mid;
					end
				end
			end
			S_FETCH: begin
				if (got_first_q) begin
					a2_q <= head_entry.position;
					b2_q <= head_entry.value;
				end else if (head_q == seg_prev) begin
					a1_q <= head_entry.position;
					b1_q <= head_entry.value;
				end
			end
			S_PREP: begin
				mdx_q  <= mag33(dx_w);
				mdy_q  <= mag33(dy_w);
				mden_q <= mag33(den_w);
				neg_q  <= dx_w[FIELD_W] ^ dy_w[FIELD_W] ^ den_w[FIELD_W];
				res_q  <= b1_q;
				stat_q <= ST_ZERO_WIDTH;
			end
			S_MUL: begin
				prod_q <= mdx_q * mdy_q;
			end
			S_SAT: begin
				res_q  <= sat_res;
				stat_q <= sat_stat;
			end
			S_DONE: begin
				if (out_free) begin
					out_data_q.result_value <= res_q;
					out_data_q.status       <= stat_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

/* rtl/core/pli_checker.sv */
// Port-level checks for the piecewise linear interpolator, bound to the top.
// Depends on pli_pkg for the payload types and status codes.
module pli_port_checker import pli_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	// A query transaction keeps the input side busy in the next cycle.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (in_data.req_type == REQ_QUERY) |=> in_stall)
		else $error("query transaction did not occupy the block");

	// A table write does not hold the input side.
	a_write_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (in_data.req_type == REQ_WRITE) |=> !in_stall)
		else $error("write transaction held the input side");

	// A new result appears only at the end of a query's work.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a query in progress");

	// A short table gives a zero result.
	a_few_points: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == ST_FEW_POINTS) |-> (out_data.result_value == '0))
		else $error("short table result is not zero");

	// A saturated result sits on a range bound.
	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == ST_SATURATED) |->
		(out_data.result_value == RES_MAX) || (out_data.result_value == RES_MIN))
		else $error("saturated result is not at a bound");

endmodule

bind piecewise_linear_interpolator_unit pli_port_checker u_pli_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
